### rtl/sfdp_pkg.sv
// ----------------------------------------------------------------------------
// SFDP basic table decoder package
// Shared field layouts, erase size codes and geometry constants.
// ----------------------------------------------------------------------------
package sfdp_pkg;

   localparam int unsigned DwordWidth    = 32;
   localparam int unsigned RevWidth      = 8;
   localparam int unsigned CapWidth      = 41;
   localparam int unsigned AddrWidth     = 3;
   localparam int unsigned OpWidth       = 8;
   localparam int unsigned BlockWidth    = 19;
   localparam int unsigned PageWidth     = 16;
   localparam int unsigned ReqDataWidth  = 176;
   localparam int unsigned RspDataWidth  = 112;
   localparam int unsigned EraseTypes    = 4;

   // Erase size exponents that map to the four opcode slots.
   localparam logic [7:0] SizeExp4K   = 8'd12;
   localparam logic [7:0] SizeExp32K  = 8'd15;
   localparam logic [7:0] SizeExp64K  = 8'd16;
   localparam logic [7:0] SizeExp256K = 8'd18;

   localparam logic [BlockWidth-1:0] Block4K   = BlockWidth'(4096);
   localparam logic [BlockWidth-1:0] Block32K  = BlockWidth'(32768);
   localparam logic [BlockWidth-1:0] Block64K  = BlockWidth'(65536);
   localparam logic [BlockWidth-1:0] Block256K = BlockWidth'(262144);

   // Address mode code in dword 1 that forces 4-byte addressing.
   localparam logic [1:0] AddrMode4Only = 2'h2;
   // 4K erase support code in dword 1.
   localparam logic [1:0] Erase4KSupported = 2'h1;

   localparam logic [CapWidth-1:0] CapLimit   = CapWidth'(64'd1 << 40);
   localparam logic [CapWidth-1:0] SixteenMib = CapWidth'(64'd16777216);
   localparam logic [5:0] ExpMin = 6'd3;
   localparam logic [5:0] ExpMax = 6'd43;
   localparam logic [RevWidth-1:0] MinorPageExp = 8'd5;

   localparam logic [AddrWidth-1:0] AddrThree = 3'd3;
   localparam logic [AddrWidth-1:0] AddrFour  = 3'd4;

   // Input transaction; the last member sits in the lowest bits.
   typedef struct packed {
      logic [RevWidth-1:0]   rev_minor;
      logic [RevWidth-1:0]   rev_major;
      logic [DwordWidth-1:0] word_page;
      logic [DwordWidth-1:0] word_erase_b;
      logic [DwordWidth-1:0] word_erase_a;
      logic [DwordWidth-1:0] word_density;
      logic [DwordWidth-1:0] word_one;
   } req_type;

   // Result transaction; the last member sits in the lowest bits.
   typedef struct packed {
      logic [PageWidth-1:0]  write_page;
      logic [BlockWidth-1:0] block_size;
      logic [OpWidth-1:0]    erase_huge_op;
      logic [OpWidth-1:0]    erase_large_op;
      logic [OpWidth-1:0]    erase_mid_op;
      logic [OpWidth-1:0]    erase_small_op;
      logic [AddrWidth-1:0]  address_bytes;
      logic                  capacity_clipped;
      logic [CapWidth-1:0]   capacity_bytes;
   } rsp_type;

endpackage

### rtl/sfdp_basic_table_decoder.sv
// ----------------------------------------------------------------------------
// SFDP basic flash parameter table decoder
// Decodes flash geometry from dwords 1, 2, 8, 9 and 11 of the basic table.
// ----------------------------------------------------------------------------
// Each request transaction carries five basic table dwords and the table
// revision; each one produces exactly one response transaction with the
// decoded capacity, address length, erase opcodes, smallest erase block and
// write page size. The block is a two-register pipeline: the request is
// captured in an input register, decoded by shallow combinational logic and
// stored in a result register; one transaction per cycle is sustained while
// the downstream side is ready. The result register is freed in the same
// cycle it is drained, so transactions flow back to back while the
// downstream side is ready. While a response is stalled, the input
// register takes one more request and then holds req_tready low until the
// response is drained.
module sfdp_basic_table_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: word_one[31:0], word_density[63:32],
   // word_erase_a[95:64], word_erase_b[127:96], word_page[159:128],
   // rev_major[167:160], rev_minor[175:168].
   input  logic [sfdp_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: capacity_bytes[40:0], capacity_clipped[41],
   // address_bytes[44:42], erase_small_op[52:45], erase_mid_op[60:53],
   // erase_large_op[68:61], erase_huge_op[76:69], block_size[95:77],
   // write_page[111:96].
   output logic [sfdp_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import sfdp_pkg::*;

   // Pipeline registers.
   logic    in_valid_ff, in_valid_in;
   req_type req_ff, req_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic out_advance;

   // The result register can load whenever it is empty or being drained.
   assign out_advance = !out_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || out_advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      req_in      = req_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         req_in      = req_type'(req_tdata);
      end
      out_valid_in = out_valid_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Capacity decode. In bit-count form the field holds bits minus one; in
   // exponent form it holds log2 of the bit count, so the byte count is a
   // single shifted one, zero below one byte and saturated at 2^40 bytes.
   // ---------------------------------------------------------------------
   logic [30:0]          density_value;
   logic [DwordWidth:0]  bit_count;
   logic                 exp_small;
   logic                 exp_large;
   logic [5:0]           byte_shift;
   logic [CapWidth-1:0]  capacity;
   logic                 clipped;

   assign density_value = req_ff.word_density[30:0];
   assign bit_count     = {1'b0, req_ff.word_density} + (DwordWidth+1)'(1);
   assign exp_small     = density_value < 31'(ExpMin);
   assign exp_large     = density_value > 31'(ExpMax);
   assign byte_shift    = density_value[5:0] - ExpMin;

   always_comb begin
      clipped = 1'b0;
      if (req_ff.word_density[DwordWidth-1]) begin
         if (exp_small) begin
            capacity = '0;
         end else if (exp_large) begin
            capacity = CapLimit;
            clipped  = 1'b1;
         end else begin
            capacity = CapWidth'(1) << byte_shift;
         end
      end else begin
         capacity = CapWidth'(bit_count >> 3);
      end
   end

   // ---------------------------------------------------------------------
   // Erase opcodes. Dword 1 seeds the 4K slot; erase types 1 to 4 then
   // overwrite the slot that matches their size exponent, later types last.
   // ---------------------------------------------------------------------
   logic [15:0]        erase_entry [EraseTypes];
   logic [OpWidth-1:0] ops [EraseTypes];
   logic [BlockWidth-1:0] block;

   assign erase_entry[0] = req_ff.word_erase_a[15:0];
   assign erase_entry[1] = req_ff.word_erase_a[31:16];
   assign erase_entry[2] = req_ff.word_erase_b[15:0];
   assign erase_entry[3] = req_ff.word_erase_b[31:16];

   always_comb begin
      ops[0] = (req_ff.word_one[1:0] == Erase4KSupported) ? req_ff.word_one[15:8] : '0;
      ops[1] = '0;
      ops[2] = '0;
      ops[3] = '0;
      for (int k = 0; k < EraseTypes; k++) begin
         case (erase_entry[k][7:0])
            SizeExp4K:   ops[0] = erase_entry[k][15:8];
            SizeExp32K:  ops[1] = erase_entry[k][15:8];
            SizeExp64K:  ops[2] = erase_entry[k][15:8];
            SizeExp256K: ops[3] = erase_entry[k][15:8];
            default: ;
         endcase
      end
   end

   // The smallest erase size with an opcode is the erase block.
   always_comb begin
      if (ops[0] != '0) begin
         block = Block4K;
      end else if (ops[1] != '0) begin
         block = Block32K;
      end else if (ops[2] != '0) begin
         block = Block64K;
      end else if (ops[3] != '0) begin
         block = Block256K;
      end else begin
         block = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Write page. Revision 1.0 to 1.4 only has the 64-byte flag; from 1.5 on
   // dword 11 gives the page size as a power of two. Other majors give 0.
   // ---------------------------------------------------------------------
   logic [PageWidth-1:0] page;

   always_comb begin
      if (req_ff.rev_major == RevWidth'(1) && req_ff.rev_minor < MinorPageExp) begin
         page = req_ff.word_one[2] ? PageWidth'(64) : PageWidth'(1);
      end else if (req_ff.rev_major == RevWidth'(1)) begin
         page = PageWidth'(1) << req_ff.word_page[7:4];
      end else begin
         page = '0;
      end
   end

   // Assemble the response.
   always_comb begin
      rsp_in = rsp_ff;
      if (out_advance) begin
         rsp_in.capacity_bytes   = capacity;
         rsp_in.capacity_clipped = clipped;
         rsp_in.address_bytes    = (capacity <= SixteenMib &&
                                    req_ff.word_one[18:17] != AddrMode4Only)
                                   ? AddrThree : AddrFour;
         rsp_in.erase_small_op   = ops[0];
         rsp_in.erase_mid_op     = ops[1];
         rsp_in.erase_large_op   = ops[2];
         rsp_in.erase_huge_op    = ops[3];
         rsp_in.block_size       = block;
         rsp_in.write_page       = page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_ff);

endmodule

### rtl/sfdp_checker.sv
// ----------------------------------------------------------------------------
// SFDP basic table decoder checker
// Port-level assertions on the decoder, attached by a bind statement.
// ----------------------------------------------------------------------------
module sfdp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [sfdp_pkg::ReqDataWidth-1:0]  req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sfdp_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import sfdp_pkg::*;

   rsp_type rsp;
   logic    req_seen;
   logic    unused_req_data;
   assign rsp             = rsp_type'(rsp_tdata);
   assign req_seen        = req_tvalid && req_tready;
   assign unused_req_data = ^req_tdata;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No response can appear unless a request was accepted and passed through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_seen, 2))
      else $error("response without a request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.address_bytes == AddrThree || rsp.address_bytes == AddrFour))
      else $error("bad address length");

   // Saturation reports the limit, and a large device needs 4-byte addresses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.capacity_clipped |->
         rsp.capacity_bytes == CapLimit && rsp.address_bytes == AddrFour)
      else $error("clipped capacity inconsistent");

   // Block size follows the smallest erase type with an opcode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp.block_size == '0) ==
         (rsp.erase_small_op == '0 && rsp.erase_mid_op == '0 &&
          rsp.erase_large_op == '0 && rsp.erase_huge_op == '0)) &&
         (rsp.block_size != Block4K || rsp.erase_small_op != '0))
      else $error("block size inconsistent with opcodes");

endmodule

bind sfdp_basic_table_decoder sfdp_checker u_sfdp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/tb_sfdp_basic_table_decoder.sv
// ----------------------------------------------------------------------------
// SFDP basic table decoder testbench
// Sends basic parameter tables over the request stream and checks every
// decoded response, field by field, against a local decoder or a typed gold.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers both density encodings and
// their edges, the 16 MiB address boundary, the four erase sizes and their
// override order, and each revision rule for the write page. About 1700
// random tables follow. They are biased toward well-formed erase entries and
// exponent densities near the limits. The sender works in bursts with random
// gaps. The receiver cycles through stall patterns of its own, so
// backpressure lands on every stage of the pipeline.
module tb_sfdp_basic_table_decoder;

   import sfdp_pkg::*;

   localparam int RandomTables = 1700;
   localparam int DrainCycles  = 8;
   localparam int CycleLimit   = 400000;

   // One row of the directed table. When typed is set, gold holds the
   // response written out by hand. Otherwise the local decoder supplies it.
   typedef struct packed {
      req_type tbl;
      logic    typed;
      rsp_type gold;
   } table_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;

   // Sideband that travels with req_tdata. The monitor reads it on the edge
   // that accepts the transaction.
   logic    pinned_typed;
   rsp_type pinned_gold;

   table_row_type directed_rows[$];
   rsp_type       expected_geometry[$];

   int cycle_count     = 0;
   int mismatch_count  = 0;
   int tables_sent     = 0;
   int responses_seen  = 0;
   int clipped_seen    = 0;
   int four_byte_seen  = 0;
   int no_erase_seen   = 0;
   int burst_left      = 0;

   sfdp_basic_table_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Decodes the geometry that one basic parameter table should produce.
   function automatic rsp_type decode_table(input req_type t);
      rsp_type         g;
      logic [30:0]     n;
      logic [3:0][7:0] slot;
      logic [15:0]     entry [4];
      g = '0;
      n = t.word_density[30:0];

      // Density is either a bit count minus one or a power-of-two exponent.
      // The exponent form is clipped at 2^40 bytes.
      if (t.word_density[31]) begin
         if (n < 3)
            g.capacity_bytes = '0;
         else if (n - 3 > 40) begin
            g.capacity_bytes   = CapWidth'(64'd1 << 40);
            g.capacity_clipped = 1'b1;
         end else
            g.capacity_bytes = CapWidth'(64'd1 << (n - 3));
      end else
         g.capacity_bytes = (CapWidth'(t.word_density) + CapWidth'(1)) >> 3;

      if (g.capacity_bytes <= CapWidth'(64'd16777216) &&
          t.word_one[18:17] != AddrMode4Only)
         g.address_bytes = AddrThree;
      else
         g.address_bytes = AddrFour;

      // Dword 1 supplies the 4K opcode first. The four erase type entries then
      // overwrite the slot of their size, in table order.
      slot    = '0;
      slot[0] = (t.word_one[1:0] == Erase4KSupported) ? t.word_one[15:8] : 8'd0;
      entry[0] = t.word_erase_a[15:0];
      entry[1] = t.word_erase_a[31:16];
      entry[2] = t.word_erase_b[15:0];
      entry[3] = t.word_erase_b[31:16];
      for (int i = 0; i < 4; i++) begin
         case (entry[i][7:0])
            SizeExp4K:   slot[0] = entry[i][15:8];
            SizeExp32K:  slot[1] = entry[i][15:8];
            SizeExp64K:  slot[2] = entry[i][15:8];
            SizeExp256K: slot[3] = entry[i][15:8];
            default: ;
         endcase
      end
      g.erase_small_op = slot[0];
      g.erase_mid_op   = slot[1];
      g.erase_large_op = slot[2];
      g.erase_huge_op  = slot[3];

      if (slot[0] != 0)
         g.block_size = Block4K;
      else if (slot[1] != 0)
         g.block_size = Block32K;
      else if (slot[2] != 0)
         g.block_size = Block64K;
      else if (slot[3] != 0)
         g.block_size = Block256K;
      else
         g.block_size = '0;

      // Before revision 1.5 the page is 64 bytes or a single byte. From 1.5
      // on, dword 11 gives its exponent. Other major revisions have no page.
      if (t.rev_major == 8'd1 && t.rev_minor < MinorPageExp)
         g.write_page = t.word_one[2] ? 16'd64 : 16'd1;
      else if (t.rev_major == 8'd1)
         g.write_page = 16'd1 << t.word_page[7:4];
      else
         g.write_page = '0;
      return g;
   endfunction

   // One erase type entry: mostly one of the four sizes that the decoder
   // knows, sometimes an arbitrary exponent, and now and then a zero opcode.
   function automatic logic [15:0] random_erase_entry();
      logic [7:0] size_exp;
      logic [7:0] opcode;
      case ($urandom_range(0, 9))
         0, 1:    size_exp = SizeExp4K;
         2, 3:    size_exp = SizeExp32K;
         4, 5:    size_exp = SizeExp64K;
         6:       size_exp = SizeExp256K;
         default: size_exp = 8'($urandom);
      endcase
      opcode = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
      return {opcode, size_exp};
   endfunction

   function automatic req_type random_table();
      req_type t;
      t.word_one = $urandom;
      if ($urandom_range(0, 2) == 0)
         t.word_one[1:0] = Erase4KSupported;
      case ($urandom_range(0, 3))
         0: t.word_density = {1'b0, 31'($urandom)};
         // Bit counts that straddle the 16 MiB boundary.
         1: t.word_density = {1'b0, 31'($urandom_range(32'h07FF_FFF0, 32'h0800_0010))};
         // Exponents around the byte floor and the 2^40 ceiling.
         2: t.word_density = {1'b1, 31'($urandom_range(0, 50))};
         default: t.word_density = {1'b1, 31'($urandom)};
      endcase
      t.word_erase_a = {random_erase_entry(), random_erase_entry()};
      t.word_erase_b = {random_erase_entry(), random_erase_entry()};
      t.word_page    = $urandom;
      t.rev_major    = ($urandom_range(0, 9) < 7) ? 8'd1 : 8'($urandom);
      t.rev_minor    = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 8))
                                                  : 8'($urandom);
      return t;
   endfunction

   task automatic add_row(input logic [31:0] one, density, erase_a, erase_b, page,
                          input logic [7:0] major, minor,
                          input logic typed = 1'b0, input rsp_type gold = '0);
      table_row_type row;
      row.tbl.word_one     = one;
      row.tbl.word_density = density;
      row.tbl.word_erase_a = erase_a;
      row.tbl.word_erase_b = erase_b;
      row.tbl.word_page    = page;
      row.tbl.rev_major    = major;
      row.tbl.rev_minor    = minor;
      row.typed            = typed;
      row.gold             = gold;
      directed_rows.push_back(row);
   endtask

   // Presents one table and returns on the edge that accepts it. The valid
   // stays high so that a following call can continue the burst without a
   // bubble.
   task automatic send_table(input req_type tbl, input logic typed, input rsp_type gold);
      req_tdata    <= tbl;
      req_tvalid   <= 1'b1;
      pinned_typed <= typed;
      pinned_gold  <= gold;
      do @(posedge clock); while (!req_tready);
      tables_sent++;
   endtask

   // Ends the current burst with a random gap once its length is used up.
   // Some bursts run straight into the next one.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want, got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // The receiver steps through four stall patterns by cycle_count[8:7]:
   // always ready, a coin toss, mostly stalled, and a fixed two-in-eight stall.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset)
         rsp_tready <= 1'b0;
      else begin
         case (cycle_count[8:7])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= (cycle_count[2:0] != 3'd3 && cycle_count[2:0] != 3'd4);
         endcase
      end
   end

   // Both channels are observed in one process. A request accepted on the
   // same edge as a response is therefore queued before that response is
   // checked, whatever the latency of the block.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_geometry.push_back(pinned_typed ? pinned_gold
                                                     : decode_table(req_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            if (expected_geometry.size() == 0) begin
               $error("response transaction arrived with no table pending");
               mismatch_count++;
            end else begin
               want = expected_geometry.pop_front();
               responses_seen++;
               if (want.capacity_clipped) clipped_seen++;
               if (want.address_bytes == AddrFour) four_byte_seen++;
               if (want.block_size == 0) no_erase_seen++;
               check_field("capacity_bytes", 64'(want.capacity_bytes), 64'(got.capacity_bytes));
               check_field("capacity_clipped", 64'(want.capacity_clipped),
                           64'(got.capacity_clipped));
               check_field("address_bytes", 64'(want.address_bytes), 64'(got.address_bytes));
               check_field("erase_small_op", 64'(want.erase_small_op), 64'(got.erase_small_op));
               check_field("erase_mid_op", 64'(want.erase_mid_op), 64'(got.erase_mid_op));
               check_field("erase_large_op", 64'(want.erase_large_op), 64'(got.erase_large_op));
               check_field("erase_huge_op", 64'(want.erase_huge_op), 64'(got.erase_huge_op));
               check_field("block_size", 64'(want.block_size), 64'(got.block_size));
               check_field("write_page", 64'(want.write_page), 64'(got.write_page));
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      rsp_type gold;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      pinned_typed = 1'b0;
      pinned_gold  = '0;

      // An all-zero table: empty device, no erase types, no page rule.
      gold = '0;
      gold.address_bytes = AddrThree;
      add_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b1, gold);
      // An all-ones table: the largest exponent clips, and every erase size
      // byte is unknown.
      gold = '0;
      gold.capacity_bytes   = CapLimit;
      gold.capacity_clipped = 1'b1;
      gold.address_bytes    = AddrFour;
      add_row('1, '1, '1, '1, '1, 8'hFF, 8'hFF, 1'b1, gold);
      // Exponent 44 is the first one past the ceiling.
      add_row(32'h0, 32'h8000_002C, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b1, gold);
      // Exponent density edges: the largest unclipped value, below one byte,
      // exactly one byte, exactly 16 MiB and the next size up.
      add_row(32'h0, 32'h8000_002B, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h8000_0002, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h8000_0003, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h8000_001B, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h8000_001C, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      // Bit-count density: the largest value, exactly 16 MiB, just above it.
      add_row(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h0800_0000, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h0800_0007, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      // The 4-byte-only address mode on a small device.
      add_row(32'h0004_0000, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      // 4K erase from dword 1, once supported and once with another code.
      add_row(32'h0000_2001, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0000_2003, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      // All four erase sizes. The 4K opcode from dword 1 is overridden by
      // erase type 3.
      add_row(32'h0000_2001, 32'h00FF_FFFF, 32'hD810_520F, 32'hDC12_210C, 32'h0,
              8'd1, 8'd0);
      // A zero opcode overrides the 4K slot, which leaves only 256K.
      add_row(32'h0000_2001, 32'h00FF_FFFF, 32'h0000_000C, 32'hDC12_0000, 32'h0,
              8'd1, 8'd0);
      // Erase entries with exponents that the decoder does not map.
      add_row(32'h0, 32'h00FF_FFFF, 32'h5511_200D, 32'h770E_6613, 32'h0, 8'd1, 8'd0);
      // Write page rules across the revisions.
      add_row(32'h0000_0004, 32'h0, 32'h0, 32'h0, 32'h0, 8'd1, 8'd0);
      add_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd1, 8'd4);
      add_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_00F0, 8'd1, 8'd5);
      add_row(32'h0000_0004, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF0F, 8'd1, 8'd5);
      add_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0080, 8'd1, 8'd255);
      add_row(32'h0000_0004, 32'h0, 32'h0, 32'h0, 32'h0000_0070, 8'd2, 8'd5);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_table(directed_rows[i].tbl, directed_rows[i].typed, directed_rows[i].gold);
         pace_sender();
      end
      for (int i = 0; i < RandomTables; i++) begin
         send_table(random_table(), 1'b0, '0);
         pace_sender();
      end
      req_tvalid <= 1'b0;

      // Wait for the last response, then give the pipeline time to show any
      // extra response.
      while (expected_geometry.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Summary: %0d tables sent (%0d directed), %0d responses checked.",
               tables_sent, directed_rows.size(), responses_seen);
      $display("Summary: %0d clipped densities, %0d four-byte devices, %0d without erase.",
               clipped_seen, four_byte_seen, no_erase_seen);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
